// ===== src/dos_pkg.sv =====
// Shared constants, types and helpers for the detection overlap suppressor.
// Used by dos_rescale and detection_overlap_suppressor_top; no dependencies.
`timescale 1ns / 1ps
package dos_pkg;

  localparam int CLASS_COUNT   = 36;
  localparam int MAX_KEPT      = 64;
  localparam int HEADER_LENGTH = 13;
  localparam int ROW_LENGTH    = HEADER_LENGTH + CLASS_COUNT;

  // Width of a row position, of the kept-table address and of its fill count.
  localparam int POS_W  = $clog2(ROW_LENGTH);
  localparam int KEPT_AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KEPT_CW = $clog2(MAX_KEPT + 1);

  // Rescaled corner width before saturation (Q.4 image pixels).
  localparam int CORNER_W = 23;
  localparam int BORDER_Q = 320;
  localparam int BORDER_PIX = 20;

  // Field offsets inside a row header.
  localparam int CONF_IDX   = 4;
  localparam int CORNER_IDX = 5;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PAD_X     = 3'd1;
  localparam logic [2:0] REG_PAD_Y     = 3'd2;
  localparam logic [2:0] REG_SCALE_X   = 3'd3;
  localparam logic [2:0] REG_SCALE_Y   = 3'd4;
  localparam logic [2:0] REG_ENEMY     = 3'd5;
  localparam logic [2:0] REG_FRAME_W   = 3'd6;
  localparam logic [2:0] REG_FRAME_H   = 3'd7;

  typedef enum logic [2:0] {
    S_IN, S_CHECK, S_WALK, S_STORE, S_SCALE, S_DECIDE, S_OUT, S_END
  } state_t;

  // Saturate a rescaled corner to signed 16 bits.
  function automatic logic [15:0] sat16(input logic signed [CORNER_W-1:0] v);
    logic [15:0] r;
    if (v > $signed(CORNER_W'(32767))) begin
      r = 16'h7FFF;
    end else if (v < -$signed(CORNER_W'(32768))) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== src/detection_overlap_suppressor_top.sv =====
// Detection overlap suppressor: one tensor value is taken per cycle within a row.
// The last value of a row stalls input until the row is decided: threshold check, kept-table
// walk (one memory read a cycle), store, rescale of the corners and the colour and border test.
// A passing row gives its result after the walk and holds input off until it is taken.
// Synchronous active-high reset clears control state and restores register defaults;
// the kept table needs no clearing pass, as its fill count marks valid entries.
`timescale 1ns / 1ps
module detection_overlap_suppressor_top import dos_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // Input stream: tdata[15:0] tensor_value; tlast is frame_end.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,
  input  logic         s_tlast,
  // Result stream: tdata [15:0] corner0_x, [31:16] corner0_y, [47:32] corner1_x,
  // [63:48] corner1_y, [79:64] corner2_x, [95:80] corner2_y, [111:96] corner3_x,
  // [127:112] corner3_y, [133:128] class_label, [149:134] raw_confidence,
  // [150] kept_table_full, [151] zero.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration registers.
  logic signed [15:0] score_threshold;
  logic [9:0]  pad_x, pad_y;
  logic [15:0] scale_x, scale_y;
  logic        enemy_is_blue;
  logic [11:0] frame_width, frame_height;

  // Row state.
  state_t state, state_next;
  logic [POS_W-1:0]   pos;
  logic signed [15:0] row_fields [HEADER_LENGTH];
  logic signed [15:0] best_score;
  logic [5:0]         best_class;
  logic               end_pending;

  // Kept table and walk.
  logic [63:0]        kept_mem [MAX_KEPT];
  logic [63:0]        rd_data;
  logic               rd_valid;
  logic [KEPT_CW-1:0] walk_idx;
  logic [KEPT_CW-1:0] kept_count;
  logic               overflow_flag;

  // Rescale sequencing.
  logic [3:0]                 sc;
  logic signed [CORNER_W-1:0] corner [8];
  logic signed [CORNER_W-1:0] scaled;
  logic signed [15:0]         sc_value;

  logic [151:0] out_data;
  logic         in_acc, last_pos, below, hit, pass;
  logic [2:0]   wr_idx;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IN);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = out_data;
  assign in_acc   = s_tvalid && s_tready;
  assign last_pos = (pos == POS_W'(ROW_LENGTH - 1));
  assign below    = row_fields[CONF_IDX] < score_threshold;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= 16'sd4;
      pad_x <= '0;
      pad_y <= '0;
      scale_x <= 16'd4096;
      scale_y <= 16'd4096;
      enemy_is_blue <= 1'b0;
      frame_width <= 12'd640;
      frame_height <= 12'd640;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_THRESHOLD: score_threshold <= pwdata[15:0];
        REG_PAD_X:     pad_x <= pwdata[9:0];
        REG_PAD_Y:     pad_y <= pwdata[9:0];
        REG_SCALE_X:   scale_x <= pwdata[15:0];
        REG_SCALE_Y:   scale_y <= pwdata[15:0];
        REG_ENEMY:     enemy_is_blue <= pwdata[0];
        REG_FRAME_W:   frame_width <= pwdata[11:0];
        REG_FRAME_H:   frame_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      REG_THRESHOLD: prdata = {16'h0000, score_threshold};
      REG_PAD_X:     prdata = {22'h0, pad_x};
      REG_PAD_Y:     prdata = {22'h0, pad_y};
      REG_SCALE_X:   prdata = {16'h0000, scale_x};
      REG_SCALE_Y:   prdata = {16'h0000, scale_y};
      REG_ENEMY:     prdata = {31'h0, enemy_is_blue};
      REG_FRAME_W:   prdata = {20'h0, frame_width};
      REG_FRAME_H:   prdata = {20'h0, frame_height};
      default:       prdata = '0;
    endcase
  end

  // Overlap of the current row's box with the kept entry just read.
  always_comb begin
    logic signed [16:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [16:0] ex_a, ex_b, ey_a, ey_b, lo_x, lo_y, hi_x, hi_y;
    ax = 17'(row_fields[0]);
    ay = 17'(row_fields[1]);
    aw = 17'(row_fields[2]);
    ah = 17'(row_fields[3]);
    bx = 17'($signed(rd_data[15:0]));
    by = 17'($signed(rd_data[31:16]));
    bw = 17'($signed(rd_data[47:32]));
    bh = 17'($signed(rd_data[63:48]));
    ex_a = ax + aw;
    ex_b = bx + bw;
    ey_a = ay + ah;
    ey_b = by + bh;
    hi_x = (ex_a < ex_b) ? ex_a : ex_b;
    hi_y = (ey_a < ey_b) ? ey_a : ey_b;
    lo_x = (ax > bx) ? ax : bx;
    lo_y = (ay > by) ? ay : by;
    hit = (aw > 0) && (ah > 0) && (bw > 0) && (bh > 0) && (hi_x > lo_x) && (hi_y > lo_y);
  end

  // Colour filter and border test on the rescaled corners.
  always_comb begin
    logic signed [CORNER_W-1:0] lim_x, lim_y, mn_x, mn_y, mx_x, mx_y;
    logic col;
    lim_x = ($signed({{(CORNER_W-12){1'b0}}, frame_width}) - CORNER_W'(BORDER_PIX)) <<< 4;
    lim_y = ($signed({{(CORNER_W-12){1'b0}}, frame_height}) - CORNER_W'(BORDER_PIX)) <<< 4;
    mn_x = (corner[0] < corner[2]) ? corner[0] : corner[2];
    mn_y = (corner[1] < corner[7]) ? corner[1] : corner[7];
    mx_x = (corner[4] > corner[6]) ? corner[4] : corner[6];
    mx_y = (corner[5] > corner[3]) ? corner[5] : corner[3];
    col = (best_class < 6'd10) && (enemy_is_blue ? (best_class < 6'd5) : (best_class >= 6'd5));
    pass = col && (mn_x > CORNER_W'(BORDER_Q)) && (mn_y > CORNER_W'(BORDER_Q))
           && (mx_x < lim_x) && (mx_y < lim_y);
  end

  // Shared rescale unit, fed one corner coordinate per cycle.
  assign sc_value = row_fields[4'(CORNER_IDX) + {1'b0, sc[2:0]}];
  dos_rescale u_rescale (
    .clk    (clk),
    .value  (sc_value),
    .pad    (sc[0] ? pad_y : pad_x),
    .scale  (sc[0] ? scale_y : scale_x),
    .result (scaled)
  );
  assign wr_idx = 3'(sc - 4'd1);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IN:     if (in_acc && last_pos) state_next = S_CHECK;
      S_CHECK:  state_next = below ? S_END : S_WALK;
      S_WALK: begin
        if (rd_valid && hit) begin
          state_next = S_END;
        end else if (walk_idx == kept_count && !rd_valid) begin
          state_next = S_STORE;
        end
      end
      S_STORE:  state_next = S_SCALE;
      S_SCALE:  if (sc == 4'd8) state_next = S_DECIDE;
      S_DECIDE: state_next = pass ? S_OUT : S_END;
      S_OUT:    if (m_tready) state_next = S_END;
      S_END:    state_next = S_IN;
      default:  state_next = S_IN;
    endcase
  end

  // Row capture, frame bookkeeping and table walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      best_class <= '0;
      kept_count <= '0;
      overflow_flag <= 1'b0;
      end_pending <= 1'b0;
      rd_valid <= 1'b0;
      walk_idx <= '0;
      sc <= '0;
    end else begin
      case (state)
        S_IN: begin
          if (in_acc) begin
            if (pos < POS_W'(HEADER_LENGTH)) begin
              row_fields[pos[3:0]] <= $signed(s_tdata);
            end else if (pos == POS_W'(HEADER_LENGTH)) begin
              best_score <= $signed(s_tdata);
              best_class <= '0;
            end else if ($signed(s_tdata) > best_score) begin
              best_score <= $signed(s_tdata);
              best_class <= 6'(pos - POS_W'(HEADER_LENGTH));
            end
            if (last_pos) begin
              pos <= '0;
              end_pending <= s_tlast;
            end else if (s_tlast) begin
              pos <= '0;
              kept_count <= '0;
              overflow_flag <= 1'b0;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        S_CHECK: begin
          walk_idx <= '0;
          rd_valid <= 1'b0;
        end
        S_WALK: begin
          if (walk_idx != kept_count) begin
            walk_idx <= walk_idx + 1'b1;
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
        end
        S_STORE: begin
          sc <= '0;
          if (kept_count < KEPT_CW'(MAX_KEPT)) begin
            kept_count <= kept_count + 1'b1;
          end else begin
            overflow_flag <= 1'b1;
          end
        end
        S_SCALE: begin
          sc <= sc + 1'b1;
          if (sc != 4'd0) corner[wr_idx] <= scaled;
        end
        S_DECIDE: begin
          out_data <= {1'b0, overflow_flag, row_fields[CONF_IDX], best_class,
                       sat16(corner[7]), sat16(corner[6]), sat16(corner[5]),
                       sat16(corner[4]), sat16(corner[3]), sat16(corner[2]),
                       sat16(corner[1]), sat16(corner[0])};
        end
        S_END: begin
          if (end_pending) begin
            kept_count <= '0;
            overflow_flag <= 1'b0;
            end_pending <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Kept-box memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state == S_STORE && kept_count < KEPT_CW'(MAX_KEPT)) begin
      kept_mem[kept_count[KEPT_AW-1:0]] <= {row_fields[3], row_fields[2],
                                            row_fields[1], row_fields[0]};
    end
    rd_data <= kept_mem[walk_idx[KEPT_AW-1:0]];
  end

  // Checks on the sequencer and the kept table.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    kept_count <= KEPT_CW'(MAX_KEPT)) else $error("kept count beyond table size");
  a_no_overlap_sides: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while a result is pending");
  a_row_end: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_pos) |=> (state == S_CHECK)) else $error("row end not decided");
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_flag) |-> ($past(kept_count) == KEPT_CW'(MAX_KEPT)))
    else $error("overflow raised with room in table");

endmodule

// ===== src/dos_rescale.sv =====
// Corner rescale unit: (value - pad*16) * scale, rounded half up to Q19.4.
// One registered product per cycle; depends on dos_pkg.
`timescale 1ns / 1ps
module dos_rescale import dos_pkg::*; (
  input  logic                       clk,
  input  logic signed [15:0]         value,
  input  logic        [9:0]          pad,
  input  logic        [15:0]         scale,
  output logic signed [CORNER_W-1:0] result
);

  logic signed [17:0] diff;
  logic signed [34:0] prod;
  logic signed [34:0] rounded;

  // Remove the letterbox offset in Q12.4.
  assign diff = $signed({{2{value[15]}}, value}) - $signed({4'b0000, pad, 4'b0000});

  // Product register cuts the path before the rounding add.
  always_ff @(posedge clk) begin
    prod <= diff * $signed({1'b0, scale});
  end

  // Round half up and drop the twelve fraction bits of the scale.
  assign rounded = prod + 35'sd2048;
  assign result  = rounded[34:12];

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for detection_overlap_suppressor_top: drives tensor rows
// and register settings, predicts every emitted detection and checks it field by field.
// Depends on dos_pkg and the RTL of the suppressor only.
`timescale 1ns / 1ps
module testbench;
  import dos_pkg::*;

  localparam int SETTLE_CYCLES = 120;

  // One emitted detection as the predictor sees it.
  typedef struct {
    logic [15:0] corner [8];
    logic [5:0]  label;
    logic [15:0] conf;
    logic        full;
  } detection_t;

  // One directed row: box, logit, corner extents, winning class and framing.
  typedef struct {
    int x, y, w, h, logit;
    int xlo, ylo, xhi, yhi;
    int label, win, tie;
    int len;
    bit last;
    int exp_n;
  } row_spec_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [15:0]  s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [151:0] m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  detection_overlap_suppressor_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predictor copy of the registers.
  int thr, padx, pady, sclx, scly, blue, fw, fh;
  // Predictor copy of the row and kept-table state.
  int pos, best_sc, best_cl, kcnt;
  int rowf [HEADER_LENGTH];
  int kept [MAX_KEPT][4];
  bit ovf;

  detection_t pending_dets [$];
  int  row_expect_q [$];
  int  failures = 0;
  int  beats_sent = 0;
  bit  quiet = 0;
  bit  tx_idle_on = 1;
  bit  rx_idle_on = 1;
  int  rx_hold = 0;
  int  rx_gap = 0;

  function automatic longint rescale(int v, int pad, int scl);
    longint t;
    t = (longint'(v) - longint'(pad) * 16) * longint'(scl) + 2048;
    return t >>> 12;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic bit boxes_touch(int ax, int ay, int aw, int ah,
                                     int bx, int by, int bw, int bh);
    int lo, hi;
    if (aw <= 0 || ah <= 0 || bw <= 0 || bh <= 0) return 0;
    lo = (ax > bx) ? ax : bx;
    hi = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    if (hi - lo <= 0) return 0;
    lo = (ay > by) ? ay : by;
    hi = (ay + ah < by + bh) ? ay + ah : by + bh;
    return (hi - lo > 0);
  endfunction

  // Decision at the end of a row; returns 1 and fills det when a detection leaves.
  function automatic bit judge_row(output detection_t det);
    longint c [8];
    bit     pass;
    longint lo, hi;
    if (rowf[CONF_IDX] < thr) return 0;
    for (int i = 0; i < kcnt; i++) begin
      if (boxes_touch(rowf[0], rowf[1], rowf[2], rowf[3],
                      kept[i][0], kept[i][1], kept[i][2], kept[i][3])) return 0;
    end
    if (kcnt < MAX_KEPT) begin
      for (int k = 0; k < 4; k++) kept[kcnt][k] = rowf[k];
      kcnt++;
    end else begin
      ovf = 1;
    end
    for (int i = 0; i < 4; i++) begin
      c[2*i]   = rescale(rowf[CORNER_IDX + 2*i], padx, sclx);
      c[2*i+1] = rescale(rowf[CORNER_IDX + 2*i + 1], pady, scly);
    end
    pass = (best_cl < 10) && (blue ? best_cl < 5 : best_cl >= 5);
    lo = (c[0] < c[2]) ? c[0] : c[2];
    if (lo <= BORDER_Q) pass = 0;
    lo = (c[1] < c[7]) ? c[1] : c[7];
    if (lo <= BORDER_Q) pass = 0;
    hi = (c[4] > c[6]) ? c[4] : c[6];
    if (hi >= (longint'(fw) - BORDER_PIX) * 16) pass = 0;
    hi = (c[5] > c[3]) ? c[5] : c[3];
    if (hi >= (longint'(fh) - BORDER_PIX) * 16) pass = 0;
    if (!pass) return 0;
    for (int i = 0; i < 8; i++) det.corner[i] = clip16(c[i]);
    det.label = best_cl[5:0];
    det.conf  = rowf[CONF_IDX][15:0];
    det.full  = ovf;
    return 1;
  endfunction

  // Track every accepted input beat and queue the detection it causes.
  always @(posedge clk) begin
    int v;
    int n;
    int want_n;
    detection_t det;
    if (!rst && s_tvalid && s_tready) begin
      v = $signed(s_tdata);
      n = 0;
      beats_sent++;
      if (pos < HEADER_LENGTH) begin
        rowf[pos] = v;
      end else if (pos == HEADER_LENGTH) begin
        best_sc = v;
        best_cl = 0;
      end else if (v > best_sc) begin
        best_sc = v;
        best_cl = pos - HEADER_LENGTH;
      end
      if (pos + 1 >= ROW_LENGTH) begin
        if (judge_row(det)) begin
          pending_dets = {pending_dets, det};
          n = 1;
        end
        pos = 0;
        if (row_expect_q.size() != 0) begin
          want_n = row_expect_q.pop_front();
          if (want_n >= 0 && n != want_n) begin
            $error("row outcome: expected %0d detections, predicted %0d", want_n, n);
            failures++;
          end
        end
      end else begin
        pos++;
      end
      if (s_tlast) begin
        kcnt = 0;
        ovf = 0;
        pos = 0;
      end
    end
  end

  // Compare each detection beat with the oldest prediction.
  always @(posedge clk) begin
    detection_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dets.size() == 0) begin
        $error("unexpected detection beat %h", m_tdata);
        failures++;
      end else begin
        want = pending_dets.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (m_tdata[16*i +: 16] !== want.corner[i]) begin
            $error("corner%0d_%s: expected %h, got %h", i / 2, (i % 2) ? "y" : "x",
                   want.corner[i], m_tdata[16*i +: 16]);
            failures++;
          end
        end
        if (m_tdata[133:128] !== want.label) begin
          $error("class_label: expected %0d, got %0d", want.label, m_tdata[133:128]);
          failures++;
        end
        if (m_tdata[149:134] !== want.conf) begin
          $error("raw_confidence: expected %h, got %h", want.conf, m_tdata[149:134]);
          failures++;
        end
        if (m_tdata[150] !== want.full) begin
          $error("kept_table_full: expected %b, got %b", want.full, m_tdata[150]);
          failures++;
        end
      end
    end
  end

  // Receiver: long hold-offs on request, otherwise random stall bursts.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one tensor beat, with an occasional idle burst ahead of it.
  task automatic send_beat(input logic [15:0] v, input bit last);
    if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Send a row of values; a short row with last set is a truncated frame.
  task automatic send_row(input int vals [ROW_LENGTH], input int len, input bit last);
    for (int i = 0; i < len; i++) send_beat(vals[i][15:0], last && (i == len - 1));
  endtask

  // Wait until every predicted detection has arrived, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr  = $signed(val[15:0]);
      REG_PAD_X:     padx = val & 32'h3FF;
      REG_PAD_Y:     pady = val & 32'h3FF;
      REG_SCALE_X:   sclx = val & 32'hFFFF;
      REG_SCALE_Y:   scly = val & 32'hFFFF;
      REG_ENEMY:     blue = val & 1;
      REG_FRAME_W:   fw   = val & 32'hFFF;
      default:       fh   = val & 32'hFFF;
    endcase
  endtask

  task automatic set_all(input int t, input int px, input int py, input int sx,
                         input int sy, input int b, input int w, input int h);
    reg_write(REG_THRESHOLD, t);
    reg_write(REG_PAD_X, px);
    reg_write(REG_PAD_Y, py);
    reg_write(REG_SCALE_X, sx);
    reg_write(REG_SCALE_Y, sy);
    reg_write(REG_ENEMY, b);
    reg_write(REG_FRAME_W, w);
    reg_write(REG_FRAME_H, h);
  endtask

  // Model-space coordinate that lands on image pixel pix after rescaling.
  function automatic int place(int pix, int pad, int scl);
    longint v;
    if (scl < 1024) return $urandom_range(0, 65535) - 32768;
    v = longint'(pad) * 16 + (longint'(pix) * 16 * 4096) / scl;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  // Build a plausible row with random content around the current settings.
  task automatic make_row(output int vals [ROW_LENGTH], input bit thin_box);
    int xlo, xhi, ylo, yhi, lab, top;
    xlo = $urandom_range(15, fw / 2);
    xhi = $urandom_range(fw / 2, fw);
    ylo = $urandom_range(15, fh / 2);
    yhi = $urandom_range(fh / 2, fh);
    vals[0] = $urandom_range(0, 3000);
    vals[1] = $urandom_range(0, 3000);
    vals[2] = thin_box ? 0 : $urandom_range(0, 500) - 50;
    vals[3] = $urandom_range(0, 500) - 50;
    vals[4] = thr + $urandom_range(0, 400) - 40;
    if (vals[4] > 32767) vals[4] = 32767;
    if (vals[4] < -32768) vals[4] = -32768;
    vals[5]  = place(xlo, padx, sclx);  vals[6]  = place(ylo, pady, scly);
    vals[7]  = place(xlo, padx, sclx);  vals[8]  = place(yhi, pady, scly);
    vals[9]  = place(xhi, padx, sclx);  vals[10] = place(yhi, pady, scly);
    vals[11] = place(xhi, padx, sclx);  vals[12] = place(ylo, pady, scly);
    if ($urandom_range(0, 3) != 0) lab = blue ? $urandom_range(0, 4) : $urandom_range(5, 9);
    else lab = $urandom_range(0, CLASS_COUNT - 1);
    top = $urandom_range(0, 2000);
    for (int i = 0; i < CLASS_COUNT; i++) vals[HEADER_LENGTH + i] = $urandom_range(0, top);
    vals[HEADER_LENGTH + lab] = top;
  endtask

  task automatic noise_row(output int vals [ROW_LENGTH]);
    for (int i = 0; i < ROW_LENGTH; i++) vals[i] = $urandom_range(0, 65535) - 32768;
  endtask

  // A frame of mixed rows; a small share is noise or cut short by a frame end.
  task automatic random_frame(input int rows);
    int vals [ROW_LENGTH];
    int kind;
    for (int r = 0; r < rows; r++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        noise_row(vals);
        send_row(vals, ROW_LENGTH, r == rows - 1);
      end else if (kind == 1) begin
        make_row(vals, 0);
        send_row(vals, $urandom_range(1, ROW_LENGTH - 1), 1);
      end else begin
        make_row(vals, kind < 4);
        send_row(vals, ROW_LENGTH, r == rows - 1);
      end
    end
  endtask

  row_spec_t plan [$];

  initial begin
    int vals [ROW_LENGTH];
    row_spec_t rs;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    thr = 4; padx = 0; pady = 0; sclx = 4096; scly = 4096; blue = 0; fw = 640; fh = 640;
    pos = 0; best_sc = 0; best_cl = 0; kcnt = 0; ovf = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset settings: scale one, no padding, so corners pass through.
    //           x    y    w    h  logit  xlo    ylo   xhi   yhi  lab win tie len last exp
    plan = '{
      '{0,   0,   100, 100, 3,     400,  400,  8000, 8000, 5,  100, -1, 49, 0, 0},
      '{0,   0,   100, 100, 4,     400,  400,  8000, 8000, 5,  100, -1, 49, 0, 1},
      '{50,  50,  100, 100, 900,   400,  400,  8000, 8000, 6,  100, -1, 49, 0, 0},
      '{100, 0,   100, 100, 900,   400,  400,  8000, 8000, 7,  100, -1, 49, 0, 1},
      '{500, 0,   10,  10,  900,   400,  400,  8000, 8000, 4,  100, -1, 49, 0, 0},
      '{600, 0,   10,  10,  900,   400,  400,  8000, 8000, 10, 100, -1, 49, 0, 0},
      '{700, 0,   10,  10,  900,   400,  400,  8000, 8000, 35, 100, -1, 49, 0, 0},
      '{800, 0,   10,  10,  900,   400,  400,  8000, 8000, 9,  50,  8,  49, 0, -1},
      '{0,   0,   0,   100, 900,   320,  400,  8000, 8000, 5,  100, -1, 49, 0, 0},
      '{0,   0,   0,   100, 900,   321,  321,  8000, 8000, 5,  100, -1, 49, 0, 1},
      '{0,   0,   0,   100, 900,   400,  400,  9920, 8000, 5,  100, -1, 49, 0, 0},
      '{0,   0,   0,   100, 900,   400,  400,  9919, 9919, 5,  100, -1, 49, 0, 1},
      '{0,   0,   0,   100, 900,   -32768, -32768, 32767, 32767, 5, 100, -1, 49, 0, 0},
      '{-32768, 32767, -32768, 32767, 32767, 400, 400, 8000, 8000, 5, 32767, -1, 49, 0, -1},
      '{0,   0,   100, 100, 900,   400,  400,  8000, 8000, 5,  -32768, -1, 49, 1, 0},
      '{0,   0,   100, 100, 900,   400,  400,  8000, 8000, 5,  100, -1, 20, 1, -1},
      '{0,   0,   100, 100, -32768, 400, 400,  8000, 8000, 5,  100, -1, 49, 0, 0},
      '{0,   0,   100, 100, 900,   400,  400,  8000, 8000, 5,  100, -1, 49, 1, 1}
    };
    foreach (plan[p]) begin
      rs = plan[p];
      vals[0] = rs.x; vals[1] = rs.y; vals[2] = rs.w; vals[3] = rs.h; vals[4] = rs.logit;
      vals[5] = rs.xlo; vals[6] = rs.ylo; vals[7] = rs.xlo; vals[8] = rs.yhi;
      vals[9] = rs.xhi; vals[10] = rs.yhi; vals[11] = rs.xhi; vals[12] = rs.ylo;
      for (int i = 0; i < CLASS_COUNT; i++) vals[HEADER_LENGTH + i] = -32768;
      vals[HEADER_LENGTH + rs.label] = rs.win;
      if (rs.tie >= 0) vals[HEADER_LENGTH + rs.tie] = rs.win;
      if (rs.len == ROW_LENGTH) row_expect_q = {row_expect_q, rs.exp_n};
      send_row(vals, rs.len, rs.last);
    end
    drain();

    // Extreme settings: everything passes the threshold, large pad and scale.
    set_all(-32768, 1023, 1023, 65535, 65535, 1, 4095, 4095);
    random_frame(4);
    drain();
    // Opposite extremes: only top logits pass, zero scale, frames below the border.
    set_all(32767, 0, 0, 0, 0, 0, 1, 19);
    random_frame(4);
    drain();

    // Random settings with well-formed frames until enough beats have been sent.
    for (int phase = 0; beats_sent < 750 + 12 * ROW_LENGTH; phase++) begin
      set_all($urandom_range(0, 200) - 100, $urandom_range(0, 60), $urandom_range(0, 60),
              $urandom_range(2048, 8192), $urandom_range(2048, 8192), $urandom_range(0, 1),
              $urandom_range(200, 1200), $urandom_range(200, 1200));
      for (int f = 0; f < 3; f++) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        if (phase == 0 && f == 0) rx_hold = 600;
        random_frame($urandom_range(2, 8));
      end
      // Crowded frame of zero-width boxes that never overlap, so the table overflows.
      if (phase == 0) begin
        for (int r = 0; r < MAX_KEPT + 3; r++) begin
          make_row(vals, 1);
          vals[4] = thr + 10;
          send_row(vals, ROW_LENGTH, r == MAX_KEPT + 2);
        end
      end
      // Sender pause until the pipeline is empty.
      s_tvalid <= 1'b0;
      while (pending_dets.size() != 0) @(posedge clk);
      random_frame(2);
      drain();
    end

    // Final stretch without idling on either side.
    quiet = 1;
    random_frame(6);
    drain();

    if (failures == 0 && pending_dets.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
